[rtl/core/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared action codes, sequencer states and result flag layout for the
// bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam logic [3:0] ACT_PUSH_FRONT = 4'd0;
    localparam logic [3:0] ACT_PUSH_BACK  = 4'd1;
    localparam logic [3:0] ACT_POP_FRONT  = 4'd2;
    localparam logic [3:0] ACT_POP_BACK   = 4'd3;
    localparam logic [3:0] ACT_CLEAR      = 4'd4;
    localparam logic [3:0] ACT_DELETE     = 4'd5;
    localparam logic [3:0] ACT_PRINT_ALL  = 4'd6;
    localparam logic [3:0] ACT_FIRST_N    = 4'd7;
    localparam logic [3:0] ACT_LAST_N     = 4'd8;

    localparam int DATA_W   = 32;
    localparam int ACTION_W = 4;

    // result flags in m_axis_tuser, lowest bit first
    localparam int FLAG_HAS   = 0;
    localparam int FLAG_EMPTY = 1;
    localparam int FLAG_OVF   = 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRD,
        S_PLD,
        S_DRD,
        S_DCMP
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              ovf;
        logic              empty;
        logic              has;
        logic              last;
    } t_result;

endpackage

[rtl/core/bounded_deque_with_value_delete.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_value_delete
// Bounded deque of signed 32-bit values in a circular RAM bank, with
// push/pop at both ends, clear, order-keeping delete by value and prints.
// ----------------------------------------------------------------------------
//  channel   dir  tdata            tuser                         tlast
//  s_axis    in   operand [31:0]   action [3:0]                  -
//  m_axis    out  data [31:0]      has_data, is_empty, overflow  last
//
//  Push, pop, clear and unused codes are handled in IDLE; so is a print or
//  push that answers with a single word. A print or a delete walks its
//  entries one by one: each entry is read from RAM (PRD, DRD) and then
//  used from the registered read data (PLD, DCMP).
//  Delete copies kept entries into the second bank, then swaps banks.
//  Input is held off while a walk runs or the output word is stalled.
//  Reset clears state, pointers, count, bank select and output valid only; no clearing pass.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_delete #(
    parameter int DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bdq_pkg::DATA_W-1:0]      s_axis_tdata,   // operand
    input  logic [bdq_pkg::ACTION_W-1:0]    s_axis_tuser,   // action
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bdq_pkg::DATA_W-1:0]      m_axis_tdata,   // data
    output logic [2:0]                      m_axis_tuser,   // has_data, is_empty, overflow
    output logic                            m_axis_tlast
);
    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state          r_state;
    t_state          n_state;
    logic [AW-1:0]   r_front;
    logic [CW-1:0]   r_count;
    logic            r_sel;
    logic [CW-1:0]   r_pos;
    logic [CW-1:0]   r_end;
    logic [CW-1:0]   r_wcnt;
    logic [DATA_W-1:0] r_val;
    logic            r_ovalid;
    t_result         r_out;

    logic            out_free;
    logic            accept;
    logic            full;
    logic            is_push;
    logic            is_print;
    logic [CW-1:0]   len;
    logic [CW-1:0]   start;
    logic            ld;
    t_result         ld_res;
    logic [1:0]      mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]   mem_raddr;
    logic [DATA_W-1:0] bank_rdata [2];
    logic [DATA_W-1:0] rdata;
    logic            keep;
    logic [CW-1:0]   wcnt_next;
    logic            walk_end;
    logic [AW-1:0]   front_dec;
    logic [AW-1:0]   front_inc;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [CW-1:0] pos);
        logic [CW:0] s;
        s = (CW+1)'(front) + (CW+1)'(pos);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign out_free  = !r_ovalid || m_axis_tready;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign full      = (r_count == CW'(DEPTH));
    assign is_push   = (s_axis_tuser == ACT_PUSH_FRONT) || (s_axis_tuser == ACT_PUSH_BACK);
    assign is_print  = (s_axis_tuser == ACT_PRINT_ALL) || (s_axis_tuser == ACT_FIRST_N)
                       || (s_axis_tuser == ACT_LAST_N);
    assign rdata     = bank_rdata[r_sel];
    assign keep      = (rdata != r_val);
    assign wcnt_next = r_wcnt + CW'(keep);
    assign walk_end  = ((r_pos + CW'(1)) == r_end);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign mem_raddr = slot_of(r_front, r_pos);

    always_comb begin
        len   = r_count;
        start = '0;
        unique case (s_axis_tuser)
            ACT_FIRST_N: begin
                if (!s_axis_tdata[DATA_W-1]
                    && (s_axis_tdata[DATA_W-2:0] < (DATA_W-1)'(r_count))) begin
                    len = s_axis_tdata[CW-1:0];
                end
            end
            ACT_LAST_N: begin
                if (s_axis_tdata[DATA_W-1]) begin
                    len = '0;
                end else if (s_axis_tdata[DATA_W-2:0] < (DATA_W-1)'(r_count)) begin
                    len = s_axis_tdata[CW-1:0];
                end
                start = r_count - len;
            end
            default: begin
                len   = r_count;
                start = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_print && r_count != '0 && len != '0) begin
                        n_state = S_PRD;
                    end else if (s_axis_tuser == ACT_DELETE && r_count != '0) begin
                        n_state = S_DRD;
                    end
                end
            end
            S_PRD:  n_state = S_PLD;
            S_PLD: begin
                if (out_free) begin
                    n_state = walk_end ? S_IDLE : S_PRD;
                end
            end
            S_DRD:  n_state = S_DCMP;
            S_DCMP: n_state = walk_end ? S_IDLE : S_DRD;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready = 1'b0;
        ld            = 1'b0;
        ld_res        = '0;
        mem_we        = '0;
        mem_waddr     = r_wcnt[AW-1:0];
        mem_wdata     = rdata;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = out_free;
                if (accept) begin
                    if (is_push) begin
                        if (full) begin
                            ld         = 1'b1;
                            ld_res.ovf = 1'b1;
                            ld_res.last = 1'b1;
                        end else begin
                            mem_we[r_sel] = 1'b1;
                            mem_wdata     = s_axis_tdata;
                            mem_waddr     = (s_axis_tuser == ACT_PUSH_FRONT) ? front_dec
                                            : slot_of(r_front, r_count);
                        end
                    end else if (is_print) begin
                        if (r_count == '0) begin
                            ld           = 1'b1;
                            ld_res.empty = 1'b1;
                            ld_res.last  = 1'b1;
                        end else if (len == '0) begin
                            ld          = 1'b1;
                            ld_res.last = 1'b1;
                        end
                    end
                end
            end
            S_PLD: begin
                if (out_free) begin
                    ld          = 1'b1;
                    ld_res.data = rdata;
                    ld_res.has  = 1'b1;
                    ld_res.last = walk_end;
                end
            end
            S_DCMP: begin
                mem_we[!r_sel] = keep;
            end
            default: begin
                ld = 1'b0;
            end
        endcase
    end

    for (genvar g = 0; g < 2; g++) begin : g_bank
        bdq_ram #(
            .WIDTH(DATA_W),
            .DEPTH(DEPTH)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (mem_we[g]),
            .i_waddr(mem_waddr),
            .i_wdata(mem_wdata),
            .i_raddr(mem_raddr),
            .o_rdata(bank_rdata[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= '0;
            r_count  <= '0;
            r_sel    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ld) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (s_axis_tuser)
                            ACT_PUSH_FRONT: begin
                                if (!full) begin
                                    r_front <= front_dec;
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            ACT_PUSH_BACK: begin
                                if (!full) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            ACT_POP_FRONT: begin
                                if (r_count != '0) begin
                                    r_count <= r_count - CW'(1);
                                    r_front <= (r_count == CW'(1)) ? '0 : front_inc;
                                end
                            end
                            ACT_POP_BACK: begin
                                if (r_count != '0) begin
                                    r_count <= r_count - CW'(1);
                                    if (r_count == CW'(1)) begin
                                        r_front <= '0;
                                    end
                                end
                            end
                            ACT_CLEAR: begin
                                r_count <= '0;
                                r_front <= '0;
                            end
                            ACT_DELETE: begin
                                if (r_count == '0) begin
                                    r_front <= '0;
                                end
                            end
                            default: begin
                                r_count <= r_count;
                            end
                        endcase
                    end
                end
                S_DCMP: begin
                    if (walk_end) begin
                        r_sel   <= !r_sel;
                        r_front <= '0;
                        r_count <= wcnt_next;
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_out <= ld_res;
        end
        unique case (r_state)
            S_IDLE: begin
                r_val  <= s_axis_tdata;
                r_wcnt <= '0;
                if (s_axis_tuser == ACT_DELETE) begin
                    r_pos <= '0;
                    r_end <= r_count;
                end else begin
                    r_pos <= start;
                    r_end <= start + len;
                end
            end
            S_PLD: begin
                if (out_free) begin
                    r_pos <= r_pos + CW'(1);
                end
            end
            S_DCMP: begin
                r_wcnt <= wcnt_next;
                r_pos  <= r_pos + CW'(1);
            end
            default: begin
                r_pos <= r_pos;
            end
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out.data;
    assign m_axis_tuser  = {r_out.ovf, r_out.empty, r_out.has};
    assign m_axis_tlast  = r_out.last;

endmodule

[rtl/core/bdq_ram.sv]
// ----------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/bdq_checker.sv]
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the result stream of the bounded deque, bound to
// the top level.
// ----------------------------------------------------------------------------
module bdq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [bdq_pkg::DATA_W-1:0]   s_axis_tdata,
    input logic [bdq_pkg::ACTION_W-1:0] s_axis_tuser,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [bdq_pkg::DATA_W-1:0]   m_axis_tdata,
    input logic [2:0]                   m_axis_tuser,
    input logic                         m_axis_tlast
);
    import bdq_pkg::*;

    logic unused_in;
    assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ (^s_axis_tuser);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_ovf_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[FLAG_OVF]
        |-> m_axis_tlast && !m_axis_tuser[FLAG_HAS] && !m_axis_tuser[FLAG_EMPTY])
        else $error("overflow word malformed");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[FLAG_EMPTY]
        |-> m_axis_tlast && !m_axis_tuser[FLAG_HAS] && !m_axis_tuser[FLAG_OVF])
        else $error("empty word malformed");

    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[FLAG_HAS] |-> m_axis_tdata == '0)
        else $error("data nonzero on word without entry");

endmodule

bind bounded_deque_with_value_delete bdq_checker u_bdq_checker (.*);
